// File: hw/rtl/rrts_pkg.sv
package rrts_pkg;

  localparam int MaxTasks = 16;
  localparam int TaskW    = 4;
  localparam int CountW   = 5;
  localparam int SliceW   = 16;
  localparam int PeriodW  = 10;
  localparam int MsW      = 32;

  localparam logic [SliceW-1:0]  SliceReset  = 16'd10;
  localparam logic [PeriodW-1:0] PeriodReset = 10'd10;

  localparam logic CFG_SLICE  = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_TICK   = 2'd1,
    OP_YIELD  = 2'd2,
    OP_SLEEP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TS_FREE  = 2'd0,
    TS_READY = 2'd1,
    TS_SLEEP = 2'd2
  } tstat_t;

  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_LOAD   = 4'd1,
    CMD_CREATE = 4'd2,
    CMD_YIELD  = 4'd3,
    CMD_SLEEP  = 4'd4,
    CMD_SLICE  = 4'd5,
    CMD_DISP   = 4'd6,
    CMD_WALK   = 4'd7,
    CMD_OUT    = 4'd8
  } cmd_t;

  typedef struct packed {
    logic count_le1;
    logic sleep_ok;
    logic expired;
    logic walk_end;
    logic div_done;
  } stat_t;

endpackage

// File: hw/rtl/rrts_div.sv
module rrts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rrts_pkg::MsW-1:0]      dividend,
  input  logic [rrts_pkg::PeriodW-1:0]  divisor,
  output logic                          done,
  output logic [rrts_pkg::MsW-1:0]      quot,
  output logic                          rem_nz
);

  logic                         busy;
  logic [4:0]                   cnt;
  logic [rrts_pkg::MsW-1:0]     q;
  logic [rrts_pkg::PeriodW-1:0] r;
  logic [rrts_pkg::PeriodW:0]   shifted;
  logic [rrts_pkg::PeriodW:0]   diff;
  logic                         ge;

  always_comb begin
    shifted = {r, q[rrts_pkg::MsW-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      q    <= dividend;
      r    <= '0;
    end else if (busy) begin
      // one quotient bit per cycle, restoring
      r   <= ge ? diff[rrts_pkg::PeriodW-1:0] : shifted[rrts_pkg::PeriodW-1:0];
      q   <= {q[rrts_pkg::MsW-2:0], ge};
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot   = q;
  assign rem_nz = (r != '0);

endmodule

// File: hw/rtl/rrts_dp.sv
module rrts_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  rrts_pkg::cmd_t                cmd,
  output rrts_pkg::stat_t               stat,
  input  logic [rrts_pkg::TaskW-1:0]    task_id,
  input  logic [rrts_pkg::MsW-1:0]      sleep_ms,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rrts_pkg::SliceW-1:0]   cfg_data,
  output logic [rrts_pkg::TaskW-1:0]    running_task,
  output logic                          idle_running,
  output logic                          switched
);

  localparam int N = rrts_pkg::MaxTasks;

  logic [rrts_pkg::SliceW-1:0]  slice_length;
  logic [rrts_pkg::PeriodW-1:0] tick_period;

  logic [rrts_pkg::TaskW-1:0]   id_q;
  logic [rrts_pkg::TaskW-1:0]   rq [N];
  logic [rrts_pkg::TaskW-1:0]   head;
  logic [rrts_pkg::CountW-1:0]  count;
  logic [rrts_pkg::TaskW-1:0]   sorder [N];
  logic [rrts_pkg::CountW-1:0]  scount;
  logic [rrts_pkg::MsW-1:0]     srem [N];
  logic [rrts_pkg::SliceW-1:0]  slice_rem [N+1];
  logic [rrts_pkg::TaskW-1:0]   cur;
  logic                         idle;
  rrts_pkg::tstat_t             tstat [N];
  logic [rrts_pkg::CountW-1:0]  walk_i;
  logic [rrts_pkg::CountW-1:0]  kept;
  logic                         sw;

  logic [rrts_pkg::SliceW-1:0]  full_slice;
  logic [rrts_pkg::PeriodW-1:0] divisor;
  logic [rrts_pkg::TaskW-1:0]   tail;
  logic [rrts_pkg::TaskW-1:0]   head_task;
  logic [rrts_pkg::CountW-1:0]  slot;
  logic [rrts_pkg::TaskW-1:0]   walk_task;
  logic [rrts_pkg::MsW-1:0]     walk_rem;
  logic [rrts_pkg::MsW-1:0]     walk_rem_next;
  logic [rrts_pkg::MsW-1:0]     ticks;
  logic [rrts_pkg::MsW-1:0]     quot;
  logic                         rem_nz;
  logic                         div_done;

  rrts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd == rrts_pkg::CMD_LOAD),
    .dividend (sleep_ms),
    .divisor  (divisor),
    .done     (div_done),
    .quot     (quot),
    .rem_nz   (rem_nz)
  );

  always_comb begin
    full_slice    = (slice_length == '0) ? 16'd1 : slice_length;
    divisor       = (tick_period == '0) ? 10'd1 : tick_period;
    tail          = head + count[rrts_pkg::TaskW-1:0];
    head_task     = rq[head];
    slot          = idle ? rrts_pkg::CountW'(N) : {1'b0, cur};
    walk_task     = sorder[walk_i[rrts_pkg::TaskW-1:0]];
    walk_rem      = srem[walk_task];
    walk_rem_next = (walk_rem == '0) ? '0 : walk_rem - 32'd1;
    ticks         = quot + {31'd0, rem_nz};

    stat.count_le1 = (count <= 5'd1);
    stat.sleep_ok  = !idle && (count != '0) && !scount[rrts_pkg::CountW-1];
    stat.expired   = (slice_rem[slot] <= 16'd1);
    stat.walk_end  = (walk_i == scount);
    stat.div_done  = div_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= rrts_pkg::SliceReset;
      tick_period  <= rrts_pkg::PeriodReset;
    end else if (cfg_we) begin
      if (cfg_index == rrts_pkg::CFG_SLICE) begin
        slice_length <= cfg_data;
      end else begin
        tick_period <= cfg_data[rrts_pkg::PeriodW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      count  <= 5'd1;
      scount <= '0;
      cur    <= '0;
      idle   <= 1'b0;
      sw     <= 1'b0;
      walk_i <= '0;
      kept   <= '0;
      for (int i = 0; i < N; i++) begin
        rq[i]    <= '0;
        tstat[i] <= (i == 0) ? rrts_pkg::TS_READY : rrts_pkg::TS_FREE;
      end
      for (int i = 0; i <= N; i++) begin
        slice_rem[i] <= rrts_pkg::SliceReset;
      end
    end else begin
      unique case (cmd)
        rrts_pkg::CMD_LOAD: begin
          id_q <= task_id;
          sw   <= 1'b0;
        end
        rrts_pkg::CMD_CREATE: begin
          if (tstat[id_q] == rrts_pkg::TS_FREE) begin
            slice_rem[id_q] <= full_slice;
            srem[id_q]      <= '0;
            rq[tail]        <= id_q;
            count           <= count + 5'd1;
            tstat[id_q]     <= rrts_pkg::TS_READY;
          end
        end
        rrts_pkg::CMD_YIELD: begin
          if (!stat.count_le1 && !idle) begin
            rq[tail] <= head_task;
            head     <= head + 4'd1;
          end
        end
        rrts_pkg::CMD_SLEEP: begin
          if (stat.sleep_ok) begin
            head                              <= head + 4'd1;
            count                             <= count - 5'd1;
            srem[head_task]                   <= ticks;
            sorder[scount[rrts_pkg::TaskW-1:0]] <= head_task;
            scount                            <= scount + 5'd1;
            tstat[head_task]                  <= rrts_pkg::TS_SLEEP;
          end
        end
        rrts_pkg::CMD_SLICE: begin
          walk_i <= '0;
          kept   <= '0;
          if (stat.expired) begin
            slice_rem[slot] <= full_slice;
            // rotate the running task to the tail
            if (!idle && count != '0) begin
              rq[tail] <= head_task;
              head     <= head + 4'd1;
            end
          end else begin
            slice_rem[slot] <= slice_rem[slot] - 16'd1;
          end
        end
        rrts_pkg::CMD_WALK: begin
          if (!stat.walk_end) begin
            srem[walk_task] <= walk_rem_next;
            if (walk_rem_next == '0) begin
              rq[tail]         <= walk_task;
              count            <= count + 5'd1;
              tstat[walk_task] <= rrts_pkg::TS_READY;
            end else begin
              sorder[kept[rrts_pkg::TaskW-1:0]] <= walk_task;
              kept                              <= kept + 5'd1;
            end
            walk_i <= walk_i + 5'd1;
          end else begin
            scount <= kept;
          end
        end
        rrts_pkg::CMD_DISP: begin
          if (count == '0) begin
            if (!idle) begin
              idle <= 1'b1;
              sw   <= 1'b1;
            end
          end else if (idle || cur != head_task) begin
            idle <= 1'b0;
            cur  <= head_task;
            sw   <= 1'b1;
          end
        end
        rrts_pkg::CMD_OUT: begin
          running_task <= idle ? '0 : cur;
          idle_running <= idle;
          switched     <= sw;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/rrts_ctrl.sv
module rrts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       opcode,
  input  logic             ms_zero,
  output logic             out_valid,
  input  logic             out_ready,
  input  rrts_pkg::stat_t  stat,
  output rrts_pkg::cmd_t   cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CREATE = 10'b0000000010,
    S_YIELD  = 10'b0000000100,
    S_DIV    = 10'b0000001000,
    S_SLEEP  = 10'b0000010000,
    S_SLICE  = 10'b0000100000,
    S_DISP1  = 10'b0001000000,
    S_WALK   = 10'b0010000000,
    S_DISP2  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = rrts_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = rrts_pkg::CMD_LOAD;
          unique case (rrts_pkg::op_t'(opcode))
            rrts_pkg::OP_CREATE: state_next = S_CREATE;
            rrts_pkg::OP_TICK:   state_next = S_SLICE;
            rrts_pkg::OP_YIELD:  state_next = S_YIELD;
            rrts_pkg::OP_SLEEP:  state_next = ms_zero ? S_YIELD : S_DIV;
            default:             state_next = S_CREATE;
          endcase
        end
      end
      S_CREATE: begin
        cmd        = rrts_pkg::CMD_CREATE;
        state_next = S_DONE;
      end
      S_YIELD: begin
        cmd        = rrts_pkg::CMD_YIELD;
        state_next = stat.count_le1 ? S_DONE : S_DISP2;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_SLEEP;
      end
      S_SLEEP: begin
        cmd        = rrts_pkg::CMD_SLEEP;
        state_next = stat.sleep_ok ? S_DISP2 : S_DONE;
      end
      S_SLICE: begin
        cmd        = rrts_pkg::CMD_SLICE;
        state_next = stat.expired ? S_DISP1 : S_WALK;
      end
      S_DISP1: begin
        cmd        = rrts_pkg::CMD_DISP;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd = rrts_pkg::CMD_WALK;
        if (stat.walk_end) state_next = S_DISP2;
      end
      S_DISP2: begin
        cmd        = rrts_pkg::CMD_DISP;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the output register can take the beat
        if (out_free) begin
          cmd        = rrts_pkg::CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (state == S_DONE && out_free) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_out_loads_valid: assert property (@(posedge clk) disable iff (rst)
    cmd == rrts_pkg::CMD_OUT |=> out_valid)
    else $error("result load did not raise out_valid");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> state != S_IDLE)
    else $error("accepted beat left controller idle");

  a_div_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && !stat.div_done) |=> state == S_DIV)
    else $error("left divide wait before quotient done");

endmodule

// File: hw/rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler with a sleep list.
// Input channel (in_valid/in_ready): one beat is one operation selected by
// opcode: create task_id, timer tick, yield, or sleep the running task for
// sleep_ms. Output channel (out_valid/out_ready): exactly one beat per
// operation with the running task, the idle flag and a switch flag.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 slice
// length, 1 tick period in ms); write only while no operation is in flight.
// A nonzero sleep turns sleep_ms into ticks in the ms-to-tick divider (one
// quotient bit per cycle); a tick walks the sleep list one entry a cycle.
// One operation is in flight at a time; the next beat can be taken in the
// cycle after the result is loaded.
// Reset: task 0 runs, it alone is ready, nobody sleeps, all slices are 10
// and both registers return to 10.
// A stalled receiver holds the result in the output register; the block
// then finishes the next operation and waits until that beat drains.
module round_robin_task_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [rrts_pkg::TaskW-1:0]    task_id,
  input  logic [rrts_pkg::MsW-1:0]      sleep_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rrts_pkg::TaskW-1:0]    running_task,
  output logic                          idle_running,
  output logic                          switched,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rrts_pkg::SliceW-1:0]   cfg_data
);

  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .ms_zero   (sleep_ms == '0),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrts_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .task_id      (task_id),
    .sleep_ms     (sleep_ms),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .running_task (running_task),
    .idle_running (idle_running),
    .switched     (switched)
  );

endmodule
